// ===== hw/rtl/csd_pkg.sv =====
// Shared types and constants for the character stack with positional delete.
// Used by the stack cell, the top level and the port checker.
package csd_pkg;

  parameter int unsigned DefaultDepth = 64;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_ENTRY = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_REMOVE = 2'd2
  } cell_cmd_e;

  // Broadcast from the control to every cell in the chain.
  typedef struct packed {
    cell_cmd_e  cmd;
    logic       sample;
    logic [7:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/char_stack_with_positional_delete.sv =====
// Character stack with positional delete: a chain of DEPTH cells, top at cell 0.
// An input transfer's result moves through the request stage, then the output register;
// one request per cycle sustained while results drain, set by the cell chain, which
// shifts or compares all entries in the accepting cycle.
// Reset: entry count cleared, pipeline emptied; cell contents stay undefined until written.
module char_stack_with_positional_delete #(
  parameter int unsigned DEPTH = csd_pkg::DefaultDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] char_value_i,
  input  logic [6:0] position_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       found_o,
  output logic [6:0] entry_count_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  logic [CW-1:0] count_q, count_d;
  logic          accept;

  csd_pkg::cell_ctrl_t ctrl;
  csd_pkg::status_e    status_d;
  logic [IW-1:0]       rm_idx;
  logic [PW-1:0]       pos_eff, cnt_ext;

  logic [7:0]       entry_w [DEPTH];
  logic [7:0]       above_w [DEPTH];
  logic [7:0]       below_w [DEPTH];
  logic [DEPTH-1:0] match_w;

  // request stage
  logic             pend_q;
  csd_pkg::status_e pend_status_q;
  logic [CW-1:0]    pend_count_q;
  logic             pend_search_q;
  logic             move;

  // output register
  logic             out_valid_q;
  csd_pkg::status_e out_status_q;
  logic             out_found_q;
  logic [CW-1:0]    out_count_q;

  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_ext = PW'(count_q);
  assign pos_eff = (position_i == 7'd0) ? PW'(1) : PW'(position_i);

  always_comb begin
    ctrl.cmd    = csd_pkg::CMD_HOLD;
    ctrl.sample = accept;
    ctrl.value  = char_value_i;
    rm_idx      = '0;
    status_d    = csd_pkg::ST_OK;
    count_d     = count_q;
    unique case (csd_pkg::action_e'(action_i))
      csd_pkg::ACT_PUSH: begin
        if (count_q == CW'(DEPTH)) begin
          status_d = csd_pkg::ST_FULL;
        end else begin
          ctrl.cmd = csd_pkg::CMD_PUSH;
          count_d  = count_q + CW'(1);
        end
      end
      csd_pkg::ACT_POP: begin
        if (count_q == '0) begin
          status_d = csd_pkg::ST_EMPTY;
        end else begin
          ctrl.cmd = csd_pkg::CMD_REMOVE;
          count_d  = count_q - CW'(1);
        end
      end
      csd_pkg::ACT_DELETE: begin
        if (count_q == '0) begin
          status_d = csd_pkg::ST_EMPTY;
        end else if (pos_eff > cnt_ext) begin
          status_d = csd_pkg::ST_NO_ENTRY;
        end else begin
          ctrl.cmd = csd_pkg::CMD_REMOVE;
          rm_idx   = IW'(pos_eff - PW'(1));
          count_d  = count_q - CW'(1);
        end
      end
      csd_pkg::ACT_SEARCH: begin
        status_d = csd_pkg::ST_OK;
      end
      default: status_d = csd_pkg::ST_OK;
    endcase
    // drop any shift when no transfer happens
    if (!accept) ctrl.cmd = csd_pkg::CMD_HOLD;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_top
      assign above_w[k] = char_value_i;
    end else begin : g_mid
      assign above_w[k] = entry_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_bot
      assign below_w[k] = 8'd0;
    end else begin : g_up
      assign below_w[k] = entry_w[k+1];
    end

    csd_cell #(
      .DEPTH (DEPTH),
      .INDEX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .rm_idx_i (rm_idx),
      .count_i  (count_q),
      .above_i  (above_w[k]),
      .below_i  (below_w[k]),
      .entry_o  (entry_w[k]),
      .match_o  (match_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (accept)    pend_q <= 1'b1;
      else if (move) pend_q <= 1'b0;
      if (move)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status_d;
      pend_count_q  <= count_d;
      pend_search_q <= (action_i == csd_pkg::ACT_SEARCH);
    end
    if (move) begin
      out_status_q <= pend_status_q;
      out_found_q  <= pend_search_q && (|match_w);
      out_count_q  <= pend_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign entry_count_o = 7'(out_count_q);

endmodule

// ===== hw/rtl/csd_cell.sv =====
// One stack cell: holds the entry at position INDEX+1 from the top.
// Depends on csd_pkg for the broadcast control struct.
module csd_cell #(
  parameter int unsigned DEPTH = csd_pkg::DefaultDepth,
  parameter int unsigned INDEX = 0
) (
  input  logic                         clk_i,
  input  csd_pkg::cell_ctrl_t          ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]     rm_idx_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [7:0]                   above_i,
  input  logic [7:0]                   below_i,
  output logic [7:0]                   entry_o,
  output logic                         match_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0] entry_q, entry_d;
  logic       match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      csd_pkg::CMD_HOLD:   entry_d = entry_q;
      csd_pkg::CMD_PUSH:   entry_d = above_i;
      // close the gap: cells at or below the removed slot take their lower neighbor
      csd_pkg::CMD_REMOVE: if (rm_idx_i <= IW'(INDEX)) entry_d = below_i;
      default:             entry_d = entry_q;
    endcase
  end

  // only held entries take part in a search
  assign match_d = (entry_q == ctrl_i.value) && (CW'(INDEX) < count_i);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.sample) match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== hw/rtl/csd_checker.sv =====
// Port checker for the character stack with positional delete, bound to the top level.
// Depends on csd_pkg for status codes.
module csd_port_assert #(
  parameter int unsigned DEPTH = csd_pkg::DefaultDepth
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic       found_o,
  input logic [6:0] entry_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(found_o)
      && $stable(entry_count_o))
    else $error("result changed while stalled");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == csd_pkg::ST_OK)
    else $error("found set with non-ok status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == csd_pkg::ST_FULL |-> entry_count_o == 7'(DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == csd_pkg::ST_EMPTY |-> entry_count_o == 7'd0)
    else $error("empty status with nonzero count");

  // a fresh result must follow an earlier input transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without earlier transfer");

endmodule

bind char_stack_with_positional_delete csd_port_assert #(
  .DEPTH (DEPTH)
) u_csd_port_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .found_o       (found_o),
  .entry_count_o (entry_count_o)
);

// ===== dv/csd_checker.sv =====
// Port checker for the character stack: tracks the stack contents on every input transfer,
// predicts the reply and compares it with each output transfer. Depends on csd_pkg.
module csd_checker #(
  parameter int unsigned DEPTH = csd_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_value_i,
  input  logic [6:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic        found_i,
  input  logic [6:0]  entry_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    csd_pkg::status_e status;
    logic             found;
    logic [6:0]       count;
  } stack_reply_t;

  logic [7:0]   held [DEPTH];
  int unsigned  depth_used;
  stack_reply_t replies_due [$];
  stack_reply_t want;
  int unsigned  mismatches;

  assign fail_count_o = mismatches;

  // Bottom of the stack sits at index 0, the top at depth_used - 1.
  function automatic stack_reply_t apply_request(csd_pkg::action_e act, logic [7:0] chr,
                                                 logic [6:0] pos);
    stack_reply_t r;
    int unsigned  slot;
    int unsigned  i;
    r.status = csd_pkg::ST_OK;
    r.found  = 1'b0;
    unique case (act)
      csd_pkg::ACT_PUSH: begin
        if (depth_used >= DEPTH) begin
          r.status = csd_pkg::ST_FULL;
        end else begin
          held[depth_used] = chr;
          depth_used++;
        end
      end
      csd_pkg::ACT_POP: begin
        if (depth_used == 0) r.status = csd_pkg::ST_EMPTY;
        else depth_used--;
      end
      csd_pkg::ACT_DELETE: begin
        // position zero aliases the top
        slot = (pos == 7'd0) ? 1 : pos;
        if (depth_used == 0) begin
          r.status = csd_pkg::ST_EMPTY;
        end else if (slot > depth_used) begin
          r.status = csd_pkg::ST_NO_ENTRY;
        end else begin
          for (i = depth_used - slot; i + 1 < depth_used; i++) held[i] = held[i + 1];
          depth_used--;
        end
      end
      default: begin
        for (i = 0; i < depth_used; i++) begin
          if (held[i] == chr) r.found = 1'b1;
        end
      end
    endcase
    r.count = depth_used[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_used = 0;
      replies_due.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // Compare first: a reply never leaves in the cycle its request arrives.
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("reply transfer with no request outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_i);
            mismatches++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_due.push_back(apply_request(csd_pkg::action_e'(action_i), char_value_i,
                                            position_i));
      end
      pending_o <= replies_due.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for char_stack_with_positional_delete: clock, reset, request stimulus
// with random gaps, reply back-pressure and the verdict. Depends on csd_pkg and csd_checker.
module tb_top;

  localparam int unsigned StackDepth = csd_pkg::DefaultDepth;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = csd_pkg::ACT_PUSH;
  logic [7:0]  char_value = 8'h00;
  logic [6:0]  position = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        found;
  logic [6:0]  entry_count;
  logic        no_idle = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall;
  int unsigned ready_wait;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  char_stack_with_positional_delete #(
    .DEPTH(StackDepth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .char_value_i (char_value),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .found_o      (found),
    .entry_count_o(entry_count)
  );

  csd_checker #(
    .DEPTH(StackDepth)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .char_value_i (char_value),
    .position_i   (position),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .found_i      (found),
    .entry_count_i(entry_count),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Reply side: after each transfer, unless no_idle is set, draw a random stall with ready low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      ready_wait <= 0;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (out_valid) begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready  <= 1'b0;
        ready_wait <= stall - 1;
      end
    end
  end

  // Called just after the clock rises; returns when the request transfer is taken.
  task automatic send_request(input csd_pkg::action_e act, input logic [7:0] chr,
                              input logic [6:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    action     <= act;
    char_value <= chr;
    position   <= pos;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Hold off requests until every reply is back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned      push_share [5];
    csd_pkg::action_e act;
    logic [7:0]       chr;
    logic [6:0]       pos;
    int unsigned      pick;

    push_share = '{85, 50, 10, 90, 35};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-store errors, byte extremes, search hit and miss,
    // top aliasing, delete past the bottom and from the bottom.
    send_request(csd_pkg::ACT_POP,    8'h00, 7'd0);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd0);
    send_request(csd_pkg::ACT_SEARCH, 8'h00, 7'd0);
    send_request(csd_pkg::ACT_PUSH,   8'h00, 7'd0);
    send_request(csd_pkg::ACT_PUSH,   8'hFF, 7'd0);
    send_request(csd_pkg::ACT_PUSH,   8'hA5, 7'd0);
    send_request(csd_pkg::ACT_PUSH,   8'h5A, 7'd0);
    send_request(csd_pkg::ACT_SEARCH, 8'hFF, 7'd0);
    send_request(csd_pkg::ACT_SEARCH, 8'h11, 7'd0);
    send_request(csd_pkg::ACT_SEARCH, 8'h00, 7'd0);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd0);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd5);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd127);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd3);
    send_request(csd_pkg::ACT_SEARCH, 8'h00, 7'd0);
    send_request(csd_pkg::ACT_DELETE, 8'h00, 7'd1);
    send_request(csd_pkg::ACT_POP,    8'hFF, 7'd0);
    send_request(csd_pkg::ACT_PUSH,   8'h80, 7'd64);
    send_request(csd_pkg::ACT_SEARCH, 8'h80, 7'd127);
    send_request(csd_pkg::ACT_POP,    8'hFF, 7'd127);
    send_request(csd_pkg::ACT_DELETE, 8'hFF, 7'd64);
    drain_replies();

    // Random phases: the push share fills to full, churns, drains to empty, refills, then shrinks.
    for (int ph = 0; ph < 5; ph++) begin
      for (int n = 0; n < 130; n++) begin
        if (n % 40 == 0) no_idle <= ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < push_share[ph]) act = csd_pkg::ACT_PUSH;
        else act = csd_pkg::action_e'($urandom_range(1, 3));
        // a narrow byte pool makes searches hit
        chr = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 6) pos = 7'($urandom_range(0, 64));
        else if (pick < 9) pos = 7'($urandom_range(0, 3));
        else pos = 7'($urandom_range(0, 127));
        send_request(act, chr, pos);
      end
      if (ph == 1) drain_replies();
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
